// File: hdl/animation_clip_timeline_macros.svh
// ---------------------------------------------------------------------------
// animation clip timeline assertion macros
// small wrappers that vanish in synthesis
// ---------------------------------------------------------------------------
`ifndef ANIMATION_CLIP_TIMELINE_MACROS_SVH
`define ANIMATION_CLIP_TIMELINE_MACROS_SVH
`ifndef SYNTHESIS
`define ACT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ACT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ACT_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ACT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/act_pkg.sv
// ---------------------------------------------------------------------------
// act_pkg
// shared types and constants of the animation clip timeline
// ---------------------------------------------------------------------------
`default_nettype none
package act_pkg;
  localparam int unsigned CLIP_SLOTS = 8;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned PROG_W     = FRAC_BITS + 1;
  localparam int unsigned QUO_W      = FRAC_BITS + 2;

  // operation carried in the input tuser
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_PROGRESS = 2'd0,
    KIND_CLEAR    = 2'd1,
    KIND_DONE     = 2'd2,
    KIND_ADDED    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_EVAL, ST_DIV, ST_SHIFT, ST_EMIT, ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic do_add;
    logic set_time;
    logic load;
    logic eval;
    logic div_step;
    logic shift_step;
    logic emit_clip;
    logic emit_done;
    logic next_slot;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_lt_act;
    logic remove;
    logic div_busy;
    logic shift_busy;
    logic out_full;
  } sts_t;
endpackage
`default_nettype wire

// File: hdl/act_ctrl.sv
// ---------------------------------------------------------------------------
// act_ctrl
// sequencer for add and tick items
// ---------------------------------------------------------------------------
`default_nettype none
module act_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_fire_i,
  input  wire logic           in_op_i,
  input  act_pkg::sts_t       sts_i,
  output logic                idle_o,
  output act_pkg::cmd_t       cmd_o
);
  act_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= act_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      act_pkg::ST_IDLE: begin
        if (in_fire_i && in_op_i == act_pkg::OP_TICK) state_d = act_pkg::ST_LOAD;
      end
      act_pkg::ST_LOAD: begin
        if (sts_i.slot_lt_act) state_d = act_pkg::ST_EVAL;
        else state_d = act_pkg::ST_DONE;
      end
      act_pkg::ST_EVAL: begin
        if (sts_i.remove) state_d = act_pkg::ST_SHIFT;
        else state_d = act_pkg::ST_DIV;
      end
      act_pkg::ST_DIV: begin
        if (!sts_i.div_busy) state_d = act_pkg::ST_EMIT;
      end
      act_pkg::ST_SHIFT: begin
        if (!sts_i.shift_busy && !sts_i.out_full) state_d = act_pkg::ST_LOAD;
      end
      act_pkg::ST_EMIT: begin
        if (!sts_i.out_full) state_d = act_pkg::ST_LOAD;
      end
      act_pkg::ST_DONE: begin
        if (!sts_i.out_full) state_d = act_pkg::ST_IDLE;
      end
      default: state_d = act_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    idle_o = 1'b0;
    case (state_q)
      act_pkg::ST_IDLE: begin
        idle_o = !sts_i.out_full;
        cmd_o.do_add = in_fire_i && in_op_i == act_pkg::OP_ADD;
        cmd_o.set_time = in_fire_i && in_op_i == act_pkg::OP_TICK;
      end
      act_pkg::ST_LOAD: cmd_o.load = sts_i.slot_lt_act;
      act_pkg::ST_EVAL: cmd_o.eval = 1'b1;
      act_pkg::ST_DIV: cmd_o.div_step = 1'b1;
      act_pkg::ST_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        cmd_o.emit_clip = !sts_i.shift_busy && !sts_i.out_full;
      end
      act_pkg::ST_EMIT: begin
        cmd_o.emit_clip = !sts_i.out_full;
        cmd_o.next_slot = !sts_i.out_full;
      end
      act_pkg::ST_DONE: cmd_o.emit_done = !sts_i.out_full;
      default: cmd_o = '0;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/act_dp.sv
// ---------------------------------------------------------------------------
// act_dp
// clip table, serial progress divider and output register
// ---------------------------------------------------------------------------
`default_nettype none
module act_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  act_pkg::cmd_t                    cmd_i,
  input  wire logic [31:0]                 now_i,
  input  wire logic [7:0]                  eff_i,
  input  wire logic [15:0]                 par_i,
  input  wire logic                        lay_i,
  input  wire logic [30:0]                 dur_i,
  input  wire logic [15:0]                 rep_i,
  input  wire logic                        out_ready_i,
  output act_pkg::sts_t                    sts_o,
  output logic                             out_valid_o,
  output logic [1:0]                       kind_o,
  output logic [act_pkg::SLOT_W-1:0]       slot_o,
  output logic [7:0]                       eff_o,
  output logic [15:0]                      par_o,
  output logic                             lay_o,
  output logic [act_pkg::PROG_W-1:0]       prog_o,
  output logic                             last_o
);
  localparam int unsigned N = act_pkg::CLIP_SLOTS;

  logic [31:0] start_q [N];
  logic [30:0] len_q   [N];
  logic [16:0] rep_q   [N];
  logic [7:0]  eff_q   [N];
  logic [15:0] par_q   [N];
  logic        lay_q   [N];

  logic [act_pkg::CNT_W-1:0]  act_q;
  logic [31:0]                time_q;
  logic [act_pkg::SLOT_W-1:0] slot_q;
  logic [act_pkg::SLOT_W-1:0] sh_q;
  logic [31:0]                cs_q;
  logic [30:0]                cl_q;
  logic [16:0]                cr_q;
  logic [7:0]                 ce_q;
  logic [15:0]                cp_q;
  logic                       cy_q;
  logic [31:0]                rem_q;
  logic [act_pkg::QUO_W-1:0]  quo_q;
  logic [5:0]                 cnt_q;
  logic                       over_q;
  logic                       rmv_q;
  logic                       full_q;

  logic [31:0] elapsed;
  logic        pass_over;
  logic [act_pkg::SLOT_W-1:0] add_slot;
  logic [32:0] trial;
  logic [32:0] rem_sh;
  logic [act_pkg::PROG_W-1:0] prog_sat;
  logic        last_slot;

  assign elapsed   = time_q - cs_q;
  assign pass_over = elapsed >= {1'b0, cl_q};
  assign add_slot  = (act_q >= act_pkg::CNT_W'(N)) ? act_pkg::SLOT_W'(N - 1)
                                                    : act_q[act_pkg::SLOT_W-1:0];
  assign rem_sh    = {rem_q, 1'b0};
  assign trial     = rem_sh - {2'b0, cl_q};
  assign last_slot = ({1'b0, sh_q} + 4'd1) >= act_q;
  assign prog_sat  = (cl_q == '0 || over_q)
                     ? act_pkg::PROG_W'(1 << act_pkg::FRAC_BITS)
                     : quo_q[act_pkg::PROG_W-1:0];

  assign sts_o.slot_lt_act = {1'b0, slot_q} < act_q && act_q != '0 &&
                             !(slot_q == '0 && full_q);
  assign sts_o.remove      = pass_over && cr_q == '0;
  assign sts_o.div_busy    = cnt_q != '0;
  assign sts_o.shift_busy  = !last_slot;
  assign sts_o.out_full    = out_valid_o && !out_ready_i;

  // slot counter wraps past the top when the table is full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= cmd_i.next_slot && slot_q == act_pkg::SLOT_W'(N - 1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= '0;
      time_q <= '0;
      slot_q <= '0;
      cnt_q  <= '0;
      rmv_q  <= 1'b0;
    end else begin
      if (cmd_i.do_add) act_q <= act_pkg::CNT_W'(add_slot) + 4'd1;
      if (cmd_i.set_time) begin
        time_q <= now_i;
        slot_q <= '0;
      end
      if (cmd_i.next_slot) slot_q <= slot_q + 1'b1;
      if (cmd_i.eval) begin
        rmv_q <= sts_o.remove;
        cnt_q <= (sts_o.remove || cl_q == '0) ? 6'd0 : 6'(act_pkg::FRAC_BITS);
      end else if (cmd_i.div_step && cnt_q != '0) begin
        cnt_q <= cnt_q - 6'd1;
      end
      if (cmd_i.emit_clip && rmv_q) act_q <= act_q - 4'd1;
    end
  end

  // clip table and working copy
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add) begin
      start_q[add_slot] <= time_q;
      len_q[add_slot]   <= dur_i;
      rep_q[add_slot]   <= {1'b0, rep_i};
      eff_q[add_slot]   <= eff_i;
      par_q[add_slot]   <= par_i;
      lay_q[add_slot]   <= lay_i;
    end
    if (cmd_i.load) begin
      cs_q <= start_q[slot_q];
      cl_q <= len_q[slot_q];
      cr_q <= rep_q[slot_q];
      ce_q <= eff_q[slot_q];
      cp_q <= par_q[slot_q];
      cy_q <= lay_q[slot_q];
      sh_q <= slot_q;
    end
    // saturate when the remaining elapsed time still reaches the length,
    // that is when elapsed reaches twice the length after a pass ends
    if (cmd_i.eval) begin
      rem_q  <= pass_over ? elapsed - {1'b0, cl_q} : elapsed;
      quo_q  <= '0;
      over_q <= pass_over && (elapsed >= {cl_q, 1'b0});
      if (pass_over && cr_q != '0) begin
        start_q[slot_q] <= time_q;
        rep_q[slot_q]   <= cr_q - 17'd1;
      end
    end
    // restoring divider on fraction bits, one quotient bit a cycle;
    // the remainder starts below the length when not saturated
    if (cmd_i.div_step && cnt_q != '0) begin
      rem_q <= trial[32] ? rem_sh[31:0] : trial[31:0];
      quo_q <= {quo_q[act_pkg::QUO_W-2:0], !trial[32]};
    end
    // shift entries down one a cycle
    if (cmd_i.shift_step && !last_slot) begin
      start_q[sh_q] <= start_q[sh_q + 1'b1];
      len_q[sh_q]   <= len_q[sh_q + 1'b1];
      rep_q[sh_q]   <= rep_q[sh_q + 1'b1];
      eff_q[sh_q]   <= eff_q[sh_q + 1'b1];
      par_q[sh_q]   <= par_q[sh_q + 1'b1];
      lay_q[sh_q]   <= lay_q[sh_q + 1'b1];
      sh_q          <= sh_q + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.do_add || cmd_i.emit_clip || cmd_i.emit_done) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_add) begin
      kind_o <= act_pkg::KIND_ADDED;
      slot_o <= add_slot;
      eff_o  <= eff_i;
      par_o  <= par_i;
      lay_o  <= lay_i;
      prog_o <= '0;
      last_o <= 1'b1;
    end else if (cmd_i.emit_clip) begin
      kind_o <= rmv_q ? act_pkg::KIND_CLEAR : act_pkg::KIND_PROGRESS;
      slot_o <= slot_q;
      eff_o  <= ce_q;
      par_o  <= cp_q;
      lay_o  <= cy_q;
      prog_o <= rmv_q ? '0 : prog_sat;
      last_o <= 1'b0;
    end else if (cmd_i.emit_done) begin
      kind_o <= act_pkg::KIND_DONE;
      slot_o <= '0;
      eff_o  <= '0;
      par_o  <= '0;
      lay_o  <= 1'b0;
      prog_o <= '0;
      last_o <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// File: hdl/animation_clip_timeline.sv
// add item: result registered the next cycle
// tick item: each kept clip is loaded, evaluated, put through the 16-step serial
//   divider and emitted; a zero-duration clip takes no divider steps; a removal
//   shifts each later slot down one; a done result ends the walk
// output stalls stretch a walk; the next item is taken once the last is out
// reset (async, active low) empties the table and zeroes the tick time
// ---------------------------------------------------------------------------
// animation_clip_timeline
// top level: stream ports, controller and datapath
// ---------------------------------------------------------------------------
`default_nettype none
`include "animation_clip_timeline_macros.svh"
module animation_clip_timeline (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: now_ms[31:0], effect_id[39:32], effect_param[55:40],
  // on_foreground[56], duration_ms[87:57], repeat_count[103:88]
  input  wire logic [103:0] s_axis_tdata,
  // tuser: operation
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: slot_index[2:0], out_effect[10:3], out_param[26:11],
  // out_layer[27], progress[44:28]
  output logic [47:0]      m_axis_tdata,
  // tuser: kind
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);
  act_pkg::cmd_t cmd;
  act_pkg::sts_t sts;
  logic idle;
  logic in_fire;
  logic [act_pkg::SLOT_W-1:0] slot;
  logic [7:0] eff;
  logic [15:0] par;
  logic lay;
  logic [act_pkg::PROG_W-1:0] prog;

  assign s_axis_tready = idle;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata = {3'b0, prog, lay, par, eff, slot};

  act_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .in_op_i(s_axis_tuser),
    .sts_i(sts), .idle_o(idle), .cmd_o(cmd)
  );

  act_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .now_i(s_axis_tdata[31:0]), .eff_i(s_axis_tdata[39:32]),
    .par_i(s_axis_tdata[55:40]), .lay_i(s_axis_tdata[56]),
    .dur_i(s_axis_tdata[87:57]), .rep_i(s_axis_tdata[103:88]),
    .out_ready_i(m_axis_tready), .sts_o(sts),
    .out_valid_o(m_axis_tvalid), .kind_o(m_axis_tuser), .slot_o(slot),
    .eff_o(eff), .par_o(par), .lay_o(lay), .prog_o(prog),
    .last_o(m_axis_tlast)
  );

  // an add item is answered in the next cycle
  `ACT_ASSERT_NEXT(a_add_resp, clk_i, rst_ni, in_fire && !s_axis_tuser, m_axis_tvalid)
  // progress never exceeds one
  `ACT_ASSERT_IMPL(a_prog_max, clk_i, rst_ni, m_axis_tvalid, prog <= act_pkg::PROG_W'(1 << act_pkg::FRAC_BITS))
  // input is never taken during a tick walk
  `ACT_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, cmd.load, !s_axis_tready)
endmodule
`default_nettype wire

// File: dv/tb_animation_clip_timeline.sv
// ---------------------------------------------------------------------------
// tb_animation_clip_timeline
// drives add and tick items into the clip timeline, predicts every result
// from a local model of the clip table and compares results field by field
// ---------------------------------------------------------------------------
`default_nettype none
module tb_animation_clip_timeline;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned HOLDOFF_CYCLES = 600;

  typedef struct packed {
    act_pkg::kind_e kind;
    logic [2:0]  slot;
    logic [7:0]  effect;
    logic [15:0] param;
    logic        layer;
    logic [16:0] progress;
    logic        last;
  } clip_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  animation_clip_timeline u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always #2 clk_i = ~clk_i;

  // local copy of the clip table
  logic [31:0] tbl_start  [act_pkg::CLIP_SLOTS];
  logic [30:0] tbl_length [act_pkg::CLIP_SLOTS];
  logic [16:0] tbl_repeats[act_pkg::CLIP_SLOTS];
  logic [7:0]  tbl_effect [act_pkg::CLIP_SLOTS];
  logic [15:0] tbl_param  [act_pkg::CLIP_SLOTS];
  logic        tbl_layer  [act_pkg::CLIP_SLOTS];
  int unsigned tbl_count = 0;
  logic [31:0] tbl_time = '0;

  clip_result_t expected_results[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct = 26;
  int unsigned  recv_idle_pct = 26;
  logic         holdoff_req = 1'b0;
  logic         holdoff_seen = 1'b0;
  int unsigned  recv_holdoff = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want,
             cycle_count);
    error_count++;
  endtask

  function automatic clip_result_t make_result(act_pkg::kind_e k, int unsigned s,
                                               int unsigned keep,
                                               logic [16:0] p, logic l);
    clip_result_t r;
    r.kind = k; r.slot = s[2:0]; r.effect = tbl_effect[keep];
    r.param = tbl_param[keep]; r.layer = tbl_layer[keep];
    r.progress = p; r.last = l;
    return r;
  endfunction

  // predict the results of one accepted item
  task automatic predict_clip_item(input logic op, input logic [103:0] d);
    int unsigned slot, i, j;
    logic [31:0] elapsed;
    logic [63:0] prog;
    clip_result_t r;
    if (op == act_pkg::OP_ADD) begin
      slot = (tbl_count >= act_pkg::CLIP_SLOTS) ? act_pkg::CLIP_SLOTS - 1 : tbl_count;
      tbl_effect[slot] = d[39:32];
      tbl_param[slot] = d[55:40];
      tbl_layer[slot] = d[56];
      tbl_length[slot] = d[87:57];
      tbl_repeats[slot] = {1'b0, d[103:88]};
      tbl_start[slot] = tbl_time;
      tbl_count = slot + 1;
      expected_results.push_back(make_result(act_pkg::KIND_ADDED, slot, slot, '0,
                                             1'b1));
    end else begin
      tbl_time = d[31:0];
      i = 0;
      while (i < tbl_count) begin
        elapsed = tbl_time - tbl_start[i];
        if (elapsed >= {1'b0, tbl_length[i]}) begin
          tbl_start[i] = tbl_time;
          elapsed = elapsed - {1'b0, tbl_length[i]};
          if (tbl_repeats[i] == 17'd0) begin
            r = make_result(act_pkg::KIND_CLEAR, i, i, '0, 1'b0);
            for (j = i + 1; j < tbl_count; j++) begin
              tbl_start[j-1] = tbl_start[j]; tbl_length[j-1] = tbl_length[j];
              tbl_repeats[j-1] = tbl_repeats[j]; tbl_effect[j-1] = tbl_effect[j];
              tbl_param[j-1] = tbl_param[j]; tbl_layer[j-1] = tbl_layer[j];
            end
            tbl_count--;
            expected_results.push_back(r);
            continue;
          end
          tbl_repeats[i] = tbl_repeats[i] - 17'd1;
        end
        if (tbl_length[i] == 31'd0) prog = 64'h10000;
        else begin
          prog = ({32'd0, elapsed} << act_pkg::FRAC_BITS) / {33'd0, tbl_length[i]};
          if (prog > 64'h10000) prog = 64'h10000;
        end
        expected_results.push_back(make_result(act_pkg::KIND_PROGRESS, i, i,
                                               prog[16:0], 1'b0));
        i++;
      end
      r = '0; r.kind = act_pkg::KIND_DONE; r.last = 1'b1;
      expected_results.push_back(r);
    end
  endtask

  // send one item, waiting for the handshake
  task automatic send_clip_item(input logic op, input logic [31:0] now,
                                input logic [7:0] eff, input logic [15:0] par,
                                input logic fg, input logic [30:0] dur,
                                input logic [15:0] rep);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {rep, dur, fg, par, eff, now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_clip_item(op, {rep, dur, fg, par, eff, now});
    @(negedge clk_i);
  endtask

  task automatic add_clip(input logic [7:0] eff, input logic [15:0] par,
                          input logic fg, input logic [30:0] dur,
                          input logic [15:0] rep);
    send_clip_item(act_pkg::OP_ADD, $urandom, eff, par, fg, dur, rep);
  endtask

  task automatic tick_at(input logic [31:0] now);
    send_clip_item(act_pkg::OP_TICK, now, 8'($urandom), 16'($urandom),
                   1'($urandom), 31'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (220) @(negedge clk_i);
  endtask

  // directed: extremes, zero duration, removal, full table, time wrap
  task automatic test_directed();
    add_clip(8'hFF, 16'hFFFF, 1'b1, 31'h7FFFFFFF, 16'hFFFF);
    add_clip(8'h00, 16'h0000, 1'b0, 31'd0, 16'd0);
    add_clip(8'h5A, 16'h1234, 1'b1, 31'd100, 16'd1);
    tick_at(32'd50);
    tick_at(32'd150);
    tick_at(32'd400);
    tick_at(32'hFFFFFFFF);
    for (int k = 0; k < 9; k++) add_clip(8'(k), 16'(k * 300), k[0], 31'(k * 7),
                                         16'(k & 3));
    tick_at(32'd5);
    tick_at(32'd20);
    tick_at(32'd80);
    tick_at(32'hFFFFFFF0);
    wait_drained();
  endtask

  // random: mostly short clips so passes end and clips get removed
  task automatic test_random(input int unsigned items);
    logic [31:0] now;
    logic [30:0] dur;
    now = tbl_time;
    for (int unsigned k = 0; k < items; k++) begin
      if (k > items / 3 && k < items / 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end else begin
        send_idle_pct = 26; recv_idle_pct = 26;
      end
      if ($urandom_range(99) < 40) begin
        case ($urandom_range(3))
          0: dur = 31'($urandom);
          1: dur = 31'd0;
          default: dur = 31'($urandom_range(200));
        endcase
        add_clip(8'($urandom), 16'($urandom), 1'($urandom), dur,
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3)));
      end else begin
        now = ($urandom_range(15) == 0) ? $urandom : now + $urandom_range(120);
        tick_at(now);
      end
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering ticks
  task automatic test_backpressure();
    for (int k = 0; k < 8; k++) add_clip(8'($urandom), 16'($urandom), 1'($urandom),
                                         31'd1000, 16'd50);
    holdoff_req = ~holdoff_req;
    send_idle_pct = 0;
    for (int k = 0; k < 12; k++) tick_at(tbl_time + 32'd10);
    send_idle_pct = 26;
    wait_drained();
  endtask

  // result checker
  always @(posedge clk_i) begin
    clip_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind     = act_pkg::kind_e'(m_axis_tuser);
      got.slot     = m_axis_tdata[2:0];
      got.effect   = m_axis_tdata[10:3];
      got.param    = m_axis_tdata[26:11];
      got.layer    = m_axis_tdata[27];
      got.progress = m_axis_tdata[44:28];
      got.last     = m_axis_tlast;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (got.kind != want.kind)
          report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.slot != want.slot)
          report_mismatch("slot", 32'(got.slot), 32'(want.slot));
        if (got.effect != want.effect)
          report_mismatch("effect", 32'(got.effect), 32'(want.effect));
        if (got.param != want.param)
          report_mismatch("param", 32'(got.param), 32'(want.param));
        if (got.layer != want.layer)
          report_mismatch("layer", 32'(got.layer), 32'(want.layer));
        if (got.progress != want.progress)
          report_mismatch("progress", 32'(got.progress), 32'(want.progress));
        if (got.last != want.last)
          report_mismatch("last", 32'(got.last), 32'(want.last));
      end
    end
  end

  // receiver ready, with random stalls and a counted hold-off
  always @(negedge clk_i) begin
    if (recv_holdoff != 0) begin
      m_axis_tready <= 1'b0;
      recv_holdoff <= recv_holdoff - 1;
    end else if (holdoff_req != holdoff_seen) begin
      m_axis_tready <= 1'b0;
      holdoff_seen <= holdoff_req;
      recv_holdoff <= HOLDOFF_CYCLES;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_random(290);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
+incdir+hdl
hdl/act_pkg.sv
hdl/act_ctrl.sv
hdl/act_dp.sv
hdl/animation_clip_timeline.sv
dv/tb_animation_clip_timeline.sv
